// File: hdl/vsbl_pkg.sv
// ----------------------------------------------------------------------------
// vsbl_pkg
// Shared constants, codes and types of the volatility surface lookup.
// ----------------------------------------------------------------------------
package vsbl_pkg;

	localparam int MAX_EXPIRIES = 16;
	localparam int MAX_POINTS   = 32;

	localparam int SLOT_W  = $clog2(MAX_EXPIRIES);
	localparam int PT_W    = $clog2(MAX_POINTS);
	localparam int CNT_W   = PT_W + 1;
	localparam int ECNT_W  = SLOT_W + 1;
	localparam int ADDR_W  = SLOT_W + PT_W;
	localparam int DEPTH   = MAX_EXPIRIES * MAX_POINTS;

	localparam int FUNC_W     = 3;
	localparam int SLOT_FW    = 4;
	localparam int EXP_W      = 24;
	localparam int STRIKE_W   = 32;
	localparam int VOL_W      = 24;
	localparam int TOL_W      = 16;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 24;

	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_WRITE  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_BFLY   = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_DEFAULT = 2'd1;
	localparam logic [STAT_W-1:0] STAT_REJECT  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_VOL = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ARB_TOL     = 4'd1;

	localparam logic [VOL_W-1:0] DEFAULT_VOL_RST = 24'd629146;
	localparam logic [TOL_W-1:0] ARB_TOL_RST     = 16'd1;
	localparam logic [8:0]       DAYS_PER_YEAR   = 9'd365;

	typedef struct packed {
		logic [VOL_W-1:0]           down;
		logic [VOL_W-1:0]           up;
		logic signed [STRIKE_W:0]   num;
		logic signed [STRIKE_W:0]   den;
	} lerp_req_t;

endpackage

// File: hdl/vsbl_item_if.sv
// ----------------------------------------------------------------------------
// vsbl_item_if
// Input item channel: valid/ready with command payload.
// ----------------------------------------------------------------------------
interface vsbl_item_if import vsbl_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic [FUNC_W-1:0]          func;
	logic [SLOT_FW-1:0]         slot;
	logic [EXP_W-1:0]           expiry_days;
	logic signed [STRIKE_W-1:0] strike;
	logic [VOL_W-1:0]           point_vol;

	modport source (output valid, func, slot, expiry_days, strike, point_vol, input ready);
	modport sink (input valid, func, slot, expiry_days, strike, point_vol, output ready);
endinterface

// File: hdl/vsbl_result_if.sv
// ----------------------------------------------------------------------------
// vsbl_result_if
// Result channel: valid/ready with vol, butterfly flag and status.
// ----------------------------------------------------------------------------
interface vsbl_result_if import vsbl_pkg::*;;
	logic              valid;
	logic              ready;
	logic [VOL_W-1:0]  vol;
	logic              butterfly_arb;
	logic [STAT_W-1:0] status;

	modport source (output valid, vol, butterfly_arb, status, input ready);
	modport sink (input valid, vol, butterfly_arb, status, output ready);
endinterface

// File: hdl/vsbl_cfg_if.sv
// ----------------------------------------------------------------------------
// vsbl_cfg_if
// Register write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface vsbl_cfg_if import vsbl_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/vsbl_lerp.sv
// ----------------------------------------------------------------------------
// vsbl_lerp
// Clamped linear interpolation: down + trunc((up-down)*num/den), one
// multiply then a restoring divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vsbl_lerp import vsbl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  lerp_req_t        req,
	output logic             done,
	output logic [VOL_W-1:0] result
);

	localparam logic [2:0] L_IDLE = 3'd0;
	localparam logic [2:0] L_MUL  = 3'd1;
	localparam logic [2:0] L_LOAD = 3'd2;
	localparam logic [2:0] L_DIV  = 3'd3;
	localparam logic [2:0] L_FIN  = 3'd4;

	localparam int PROD_W = VOL_W + STRIKE_W;

	logic [2:0]            st_q;
	logic [VOL_W-1:0]      down_q;
	logic                  neg_q;
	logic [VOL_W-1:0]      mag_q;
	logic [STRIKE_W-1:0]   num_q;
	logic [STRIKE_W-1:0]   den_q;
	logic [PROD_W-1:0]     prod_q;
	logic [STRIKE_W-1:0]   rem_q;
	logic [VOL_W-1:0]      quo_q;
	logic [4:0]            cnt_q;
	logic                  done_q;
	logic [VOL_W-1:0]      res_q;

	logic signed [VOL_W:0] diff;
	logic [STRIKE_W:0]     trial;

	assign diff  = $signed({1'b0, req.up}) - $signed({1'b0, req.down});
	assign trial = {rem_q, prod_q[VOL_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= L_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				L_IDLE: begin
					if (start) begin
						if (req.den[STRIKE_W] || req.den == '0 ||
						    req.num[STRIKE_W] || req.num == '0) begin
							res_q  <= req.down;
							done_q <= 1'b1;
						end else if (req.num[STRIKE_W-1:0] >= req.den[STRIKE_W-1:0]) begin
							res_q  <= req.up;
							done_q <= 1'b1;
						end else begin
							down_q <= req.down;
							neg_q  <= diff[VOL_W];
							mag_q  <= diff[VOL_W] ? VOL_W'(-diff) : diff[VOL_W-1:0];
							num_q  <= req.num[STRIKE_W-1:0];
							den_q  <= req.den[STRIKE_W-1:0];
							st_q   <= L_MUL;
						end
					end
				end
				L_MUL: begin
					prod_q <= mag_q * num_q;
					st_q   <= L_LOAD;
				end
				L_LOAD: begin
					rem_q <= prod_q[PROD_W-1:VOL_W];
					quo_q <= '0;
					cnt_q <= '0;
					st_q  <= L_DIV;
				end
				L_DIV: begin
					if (trial >= {1'b0, den_q}) begin
						rem_q <= STRIKE_W'(trial - {1'b0, den_q});
						quo_q <= {quo_q[VOL_W-2:0], 1'b1};
					end else begin
						rem_q <= trial[STRIKE_W-1:0];
						quo_q <= {quo_q[VOL_W-2:0], 1'b0};
					end
					prod_q <= prod_q << 1;
					cnt_q  <= cnt_q + 5'd1;
					if (cnt_q == 5'(VOL_W - 1))
						st_q <= L_FIN;
				end
				L_FIN: begin
					res_q  <= neg_q ? down_q - quo_q : down_q + quo_q;
					done_q <= 1'b1;
					st_q   <= L_IDLE;
				end
				default: st_q <= L_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// File: hdl/vol_surface_bilinear_lookup.sv
// ----------------------------------------------------------------------------
// vol_surface_bilinear_lookup
// Volatility table with clamped bilinear lookup and butterfly check.
// Clear, write and append go straight to the result stage; a query runs an
//   expiry search, then per smile up to 6 search steps and an interpolation.
// Items are taken one at a time, set by the single strike/vol memory port
//   and the bit-serial divider; butterfly reads each smile point in turn.
// Reset: counts cleared, registers to defaults; tables undefined until written.
// ----------------------------------------------------------------------------
module vol_surface_bilinear_lookup import vsbl_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	vsbl_item_if.sink     item,
	vsbl_result_if.source result,
	vsbl_cfg_if.sink      cfg
);

	localparam logic [4:0] S_IDLE       = 5'd0;
	localparam logic [4:0] S_DONE       = 5'd1;
	localparam logic [4:0] S_QRY_START  = 5'd2;
	localparam logic [4:0] S_EXP_BS     = 5'd3;
	localparam logic [4:0] S_QRY_CHK    = 5'd4;
	localparam logic [4:0] S_SM_RD_LAST = 5'd5;
	localparam logic [4:0] S_SM_CHK_LST = 5'd6;
	localparam logic [4:0] S_SM_CHK_FST = 5'd7;
	localparam logic [4:0] S_SM_BS_RD   = 5'd8;
	localparam logic [4:0] S_SM_BS_CMP  = 5'd9;
	localparam logic [4:0] S_SM_FIX     = 5'd10;
	localparam logic [4:0] S_SM_RD_DN   = 5'd11;
	localparam logic [4:0] S_SM_RD_UP   = 5'd12;
	localparam logic [4:0] S_SM_LERP    = 5'd13;
	localparam logic [4:0] S_EXP_LERP   = 5'd14;
	localparam logic [4:0] S_BF_SLOT    = 5'd15;
	localparam logic [4:0] S_BF_RD      = 5'd16;
	localparam logic [4:0] S_BF_SQ      = 5'd17;
	localparam logic [4:0] S_BF_D       = 5'd18;
	localparam logic [4:0] S_BF_P       = 5'd19;
	localparam logic [4:0] S_BF_CMP     = 5'd20;

	localparam int SQ_W  = 2 * VOL_W;
	localparam int D_W   = SQ_W + 3;
	localparam int DM_W  = SQ_W + 2 - 24;
	localparam int BP_W  = DM_W + EXP_W;
	localparam int LIM_W = TOL_W + 9;

	logic [4:0]                 state_q;
	logic [VOL_W-1:0]           dvol_q;
	logic [TOL_W-1:0]           tol_q;
	logic [EXP_W-1:0]           exp_q [MAX_EXPIRIES];
	logic [ECNT_W-1:0]          exp_cnt_q;
	logic [CNT_W-1:0]           pcnt_q [MAX_EXPIRIES];

	logic signed [STRIKE_W-1:0] strike_mem [DEPTH];
	logic [VOL_W-1:0]           vol_mem [DEPTH];
	logic signed [STRIKE_W-1:0] strike_rd;
	logic [VOL_W-1:0]           vol_rd;
	logic [ADDR_W-1:0]          mem_addr;
	logic                       mem_we;

	logic [EXP_W-1:0]           e_q;
	logic signed [STRIKE_W-1:0] s_q;
	logic [CNT_W-1:0]           lo_q, hi_q;
	logic [SLOT_W-1:0]          sl_q, dn_q, up_q;
	logic                       phase_q;
	logic [VOL_W-1:0]           vol0_q, vdn_q, vsm_q;
	logic signed [STRIKE_W-1:0] sdn_q;

	logic [ECNT_W-1:0]          bsl_q;
	logic [CNT_W-1:0]           j_q;
	logic [SQ_W-1:0]            sqd_q, sqm_q, sqn_q;
	logic [DM_W-1:0]            dmag_q;
	logic                       dneg_q;
	logic [BP_W-1:0]            bprod_q;

	logic [VOL_W-1:0]           res_vol_q;
	logic                       res_arb_q;
	logic [STAT_W-1:0]          res_stat_q;
	logic                       out_v_q;
	logic [VOL_W-1:0]           out_vol_q;
	logic                       out_arb_q;
	logic [STAT_W-1:0]          out_stat_q;

	logic                       acc;
	logic [SLOT_W-1:0]          in_slot;
	logic                       slot_bad, app_bad;
	logic [CNT_W-1:0]           n_sm, lo_fix, mid;
	logic [SLOT_W-1:0]          nm1, exp_lf;
	logic [ECNT_W-1:0]          exp_lo;
	logic                       sm_fin;
	logic [VOL_W-1:0]           sm_val;
	logic                       lerp_start, lerp_done;
	lerp_req_t                  lerp_req;
	logic [VOL_W-1:0]           lerp_res;
	logic signed [D_W-1:0]      dval, dneg_val;
	logic [LIM_W-1:0]           lim;

	assign acc      = item.valid && item.ready;
	assign in_slot  = SLOT_W'(item.slot);
	assign slot_bad = ECNT_W'(item.slot) >= ECNT_W'(MAX_EXPIRIES);
	assign app_bad  = slot_bad || (ECNT_W'(item.slot) >= exp_cnt_q) ||
	                  (pcnt_q[in_slot] >= CNT_W'(MAX_POINTS));

	assign n_sm   = pcnt_q[sl_q];
	assign mid    = CNT_W'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
	assign lo_fix = (lo_q >= n_sm) ? n_sm - 1'b1 : lo_q;
	assign nm1    = SLOT_W'(exp_cnt_q - 1'b1);
	assign exp_lo = (ECNT_W'(lo_q) > ECNT_W'(nm1)) ? ECNT_W'(nm1) : ECNT_W'(lo_q);
	assign exp_lf = (exp_lo == '0) ? SLOT_W'(1) : SLOT_W'(exp_lo);

	assign dval     = $signed({3'b0, sqn_q}) - $signed({2'b0, sqm_q, 1'b0}) +
	                  $signed({3'b0, sqd_q});
	assign dneg_val = -dval;
	assign lim      = LIM_W'(tol_q) * LIM_W'(DAYS_PER_YEAR);

	assign mem_we = acc && item.func == FUNC_APPEND && !app_bad;

	always_comb begin
		unique case (state_q)
			S_IDLE:       mem_addr = {in_slot, pcnt_q[in_slot][PT_W-1:0]};
			S_SM_RD_LAST: mem_addr = {sl_q, PT_W'(n_sm - 1'b1)};
			S_SM_CHK_LST: mem_addr = {sl_q, {PT_W{1'b0}}};
			S_SM_BS_RD:   mem_addr = {sl_q, mid[PT_W-1:0]};
			S_SM_FIX:     mem_addr = {sl_q, PT_W'(lo_fix - 1'b1)};
			S_SM_RD_DN:   mem_addr = {sl_q, lo_q[PT_W-1:0]};
			S_BF_RD:      mem_addr = {bsl_q[SLOT_W-1:0], j_q[PT_W-1:0]};
			default:      mem_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			strike_mem[mem_addr] <= item.strike;
			vol_mem[mem_addr]    <= item.point_vol;
		end
		strike_rd <= strike_mem[mem_addr];
		vol_rd    <= vol_mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (acc && item.func == FUNC_WRITE && !slot_bad)
			exp_q[in_slot] <= item.expiry_days;
	end

	always_comb begin
		sm_fin = 1'b0;
		sm_val = vol_rd;
		case (state_q)
			S_SM_CHK_LST: sm_fin = s_q > strike_rd;
			S_SM_CHK_FST: sm_fin = s_q < strike_rd;
			S_SM_FIX: begin
				sm_fin = lo_fix == '0;
				sm_val = vol0_q;
			end
			S_SM_LERP: begin
				sm_fin = lerp_done;
				sm_val = lerp_res;
			end
			default: sm_fin = 1'b0;
		endcase
	end

	always_comb begin
		lerp_start = 1'b0;
		lerp_req.down = vdn_q;
		lerp_req.up   = vol_rd;
		lerp_req.num  = $signed({s_q[STRIKE_W-1], s_q}) - $signed({sdn_q[STRIKE_W-1], sdn_q});
		lerp_req.den  = $signed({strike_rd[STRIKE_W-1], strike_rd}) -
		                $signed({sdn_q[STRIKE_W-1], sdn_q});
		if (state_q == S_SM_RD_UP) begin
			lerp_start = 1'b1;
		end else if (sm_fin && phase_q) begin
			lerp_start    = 1'b1;
			lerp_req.down = vsm_q;
			lerp_req.up   = sm_val;
			lerp_req.num  = $signed({{(STRIKE_W+1-EXP_W){1'b0}}, e_q}) -
			                $signed({{(STRIKE_W+1-EXP_W){1'b0}}, exp_q[dn_q]});
			lerp_req.den  = $signed({{(STRIKE_W+1-EXP_W){1'b0}}, exp_q[up_q]}) -
			                $signed({{(STRIKE_W+1-EXP_W){1'b0}}, exp_q[dn_q]});
		end
	end

	vsbl_lerp u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lerp_start),
		.req    (lerp_req),
		.done   (lerp_done),
		.result (lerp_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvol_q <= DEFAULT_VOL_RST;
			tol_q  <= ARB_TOL_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_DEFAULT_VOL: dvol_q <= cfg.data[VOL_W-1:0];
				REG_ARB_TOL:     tol_q  <= cfg.data[TOL_W-1:0];
				default:         tol_q  <= tol_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			exp_cnt_q <= '0;
			out_v_q   <= 1'b0;
			for (int i = 0; i < MAX_EXPIRIES; i++)
				pcnt_q[i] <= '0;
		end else begin
			if (out_v_q && result.ready)
				out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						res_vol_q  <= '0;
						res_arb_q  <= 1'b0;
						res_stat_q <= STAT_OK;
						e_q        <= item.expiry_days;
						s_q        <= item.strike;
						state_q    <= S_DONE;
						case (item.func)
							FUNC_CLEAR: begin
								exp_cnt_q <= '0;
								for (int i = 0; i < MAX_EXPIRIES; i++)
									pcnt_q[i] <= '0;
							end
							FUNC_WRITE: begin
								if (slot_bad) begin
									res_stat_q <= STAT_REJECT;
								end else begin
									pcnt_q[in_slot] <= '0;
									if (exp_cnt_q < ECNT_W'(item.slot) + 1'b1)
										exp_cnt_q <= ECNT_W'(item.slot) + 1'b1;
								end
							end
							FUNC_APPEND: begin
								if (app_bad)
									res_stat_q <= STAT_REJECT;
								else
									pcnt_q[in_slot] <= pcnt_q[in_slot] + 1'b1;
							end
							FUNC_QUERY: state_q <= S_QRY_START;
							FUNC_BFLY: begin
								bsl_q   <= '0;
								state_q <= S_BF_SLOT;
							end
							default: res_stat_q <= STAT_OK;
						endcase
					end
				end
				S_DONE: begin
					if (!out_v_q || result.ready) begin
						out_v_q    <= 1'b1;
						out_vol_q  <= res_vol_q;
						out_arb_q  <= res_arb_q;
						out_stat_q <= res_stat_q;
						state_q    <= S_IDLE;
					end
				end
				S_QRY_START: begin
					if (exp_cnt_q == '0) begin
						res_vol_q  <= dvol_q;
						res_stat_q <= STAT_DEFAULT;
						state_q    <= S_DONE;
					end else if (exp_cnt_q == ECNT_W'(1) || e_q < exp_q[0]) begin
						dn_q    <= '0;
						up_q    <= '0;
						state_q <= S_QRY_CHK;
					end else if (e_q > exp_q[nm1]) begin
						dn_q    <= nm1;
						up_q    <= nm1;
						state_q <= S_QRY_CHK;
					end else begin
						lo_q    <= '0;
						hi_q    <= CNT_W'(exp_cnt_q);
						state_q <= S_EXP_BS;
					end
				end
				S_EXP_BS: begin
					if (lo_q < hi_q) begin
						if (exp_q[mid[SLOT_W-1:0]] < e_q)
							lo_q <= mid + 1'b1;
						else
							hi_q <= mid;
					end else begin
						dn_q    <= exp_lf - 1'b1;
						up_q    <= exp_lf;
						state_q <= S_QRY_CHK;
					end
				end
				S_QRY_CHK: begin
					if (pcnt_q[dn_q] == '0 || pcnt_q[up_q] == '0) begin
						res_stat_q <= STAT_REJECT;
						state_q    <= S_DONE;
					end else begin
						phase_q <= 1'b0;
						sl_q    <= dn_q;
						state_q <= S_SM_RD_LAST;
					end
				end
				S_SM_RD_LAST: state_q <= S_SM_CHK_LST;
				S_SM_CHK_LST: if (!sm_fin) state_q <= S_SM_CHK_FST;
				S_SM_CHK_FST: begin
					if (!sm_fin) begin
						vol0_q  <= vol_rd;
						lo_q    <= '0;
						hi_q    <= n_sm;
						state_q <= S_SM_BS_RD;
					end
				end
				S_SM_BS_RD: state_q <= (lo_q < hi_q) ? S_SM_BS_CMP : S_SM_FIX;
				S_SM_BS_CMP: begin
					if (strike_rd < s_q)
						lo_q <= mid + 1'b1;
					else
						hi_q <= mid;
					state_q <= S_SM_BS_RD;
				end
				S_SM_FIX: begin
					if (!sm_fin) begin
						lo_q    <= lo_fix;
						state_q <= S_SM_RD_DN;
					end
				end
				S_SM_RD_DN: begin
					sdn_q   <= strike_rd;
					vdn_q   <= vol_rd;
					state_q <= S_SM_RD_UP;
				end
				S_SM_RD_UP: state_q <= S_SM_LERP;
				S_SM_LERP:  state_q <= S_SM_LERP;
				S_EXP_LERP: begin
					if (lerp_done) begin
						res_vol_q <= lerp_res;
						state_q   <= S_DONE;
					end
				end
				S_BF_SLOT: begin
					if (bsl_q >= exp_cnt_q) begin
						state_q <= S_DONE;
					end else if (pcnt_q[bsl_q[SLOT_W-1:0]] < CNT_W'(3)) begin
						bsl_q <= bsl_q + 1'b1;
					end else begin
						j_q     <= '0;
						state_q <= S_BF_RD;
					end
				end
				S_BF_RD: state_q <= S_BF_SQ;
				S_BF_SQ: begin
					sqn_q   <= vol_rd * vol_rd;
					state_q <= S_BF_D;
				end
				S_BF_D: begin
					sqd_q <= sqm_q;
					sqm_q <= sqn_q;
					if (j_q >= CNT_W'(2)) begin
						dneg_q  <= dval[D_W-1];
						dmag_q  <= dneg_val[SQ_W+1:24];
						state_q <= S_BF_P;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_BF_RD;
					end
				end
				S_BF_P: begin
					bprod_q <= dmag_q * exp_q[bsl_q[SLOT_W-1:0]];
					state_q <= S_BF_CMP;
				end
				S_BF_CMP: begin
					if (dneg_q && bprod_q > BP_W'(lim)) begin
						res_arb_q <= 1'b1;
						state_q   <= S_DONE;
					end else if (j_q + 1'b1 == pcnt_q[bsl_q[SLOT_W-1:0]]) begin
						bsl_q   <= bsl_q + 1'b1;
						state_q <= S_BF_SLOT;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_BF_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (sm_fin) begin
				if (!phase_q && dn_q != up_q) begin
					vsm_q   <= sm_val;
					phase_q <= 1'b1;
					sl_q    <= up_q;
					state_q <= S_SM_RD_LAST;
				end else if (!phase_q) begin
					res_vol_q <= sm_val;
					state_q   <= S_DONE;
				end else begin
					state_q <= S_EXP_LERP;
				end
			end
		end
	end

	assign item.ready           = state_q == S_IDLE;
	assign cfg.ready            = 1'b1;
	assign result.valid         = out_v_q;
	assign result.vol           = out_vol_q;
	assign result.butterfly_arb = out_arb_q;
	assign result.status        = out_stat_q;

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the volatility surface lookup. A driver sends
// command items in random bursts, a monitor stalls the result channel on a
// pattern of its own and checks every result against a surface model kept
// here. The run steps through several register settings between phases.
// ----------------------------------------------------------------------------
module testbench import vsbl_pkg::*;;

	typedef struct packed {
		logic [FUNC_W-1:0]          func;
		logic [SLOT_FW-1:0]         slot;
		logic [EXP_W-1:0]           e;
		logic signed [STRIKE_W-1:0] s;
		logic [VOL_W-1:0]           pv;
	} cmd_t;

	typedef struct packed {
		logic [VOL_W-1:0]  vol;
		logic              arb;
		logic [STAT_W-1:0] status;
	} res_t;

	logic clk;
	logic arst_n;

	vsbl_item_if   item();
	vsbl_result_if result();
	vsbl_cfg_if    cfg();

	vol_surface_bilinear_lookup dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item.sink),
		.result (result.source),
		.cfg    (cfg.sink)
	);

	// surface model state
	longint    exp_tab [MAX_EXPIRIES];
	int        exp_cnt;
	int        pt_cnt [MAX_EXPIRIES];
	longint    stk_tab [DEPTH];
	longint    vol_tab [DEPTH];
	longint    dflt_vol;
	longint    arb_tol;

	cmd_t      pending_cmds [$];
	res_t      expected_res [$];
	int        errors;
	int        gen_cnt;
	int        nres;

	function automatic longint blend(longint dn, longint up, longint num, longint den);
		if (den <= 0 || num <= 0)
			return dn;
		if (num >= den)
			return up;
		return dn + ((up - dn) * num) / den;
	endfunction

	function automatic longint smile_at(int sl, longint s);
		int n;
		int base;
		int lo;
		int hi;
		int mid;
		n = pt_cnt[sl];
		base = sl * MAX_POINTS;
		lo = 0;
		hi = n;
		if (s > stk_tab[base + n - 1])
			return vol_tab[base + n - 1];
		if (s < stk_tab[base])
			return vol_tab[base];
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (stk_tab[base + mid] < s)
				lo = mid + 1;
			else
				hi = mid;
		end
		if (lo == 0)
			return vol_tab[base];
		if (lo >= n)
			lo = n - 1;
		if (lo == 0)
			return vol_tab[base];
		return blend(vol_tab[base + lo - 1], vol_tab[base + lo],
			s - stk_tab[base + lo - 1], stk_tab[base + lo] - stk_tab[base + lo - 1]);
	endfunction

	function automatic bit smile_nonconvex();
		int     n;
		int     b;
		longint vd;
		longint vm;
		longint vu;
		longint d;
		longint p;
		for (int sl = 0; sl < exp_cnt && sl < MAX_EXPIRIES; sl++) begin
			n = pt_cnt[sl];
			if (n < 3)
				continue;
			b = sl * MAX_POINTS;
			for (int i = 1; i + 1 < n; i++) begin
				vd = vol_tab[b + i - 1];
				vm = vol_tab[b + i];
				vu = vol_tab[b + i + 1];
				d = vu * vu - 2 * vm * vm + vd * vd;
				if (d >= 0)
					continue;
				p = ((-d) >>> 24) * exp_tab[sl];
				if (p > arb_tol * 365)
					return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic res_t surface_step(cmd_t c);
		res_t   r;
		int     n;
		int     lo;
		int     hi;
		int     mid;
		int     dn;
		int     up;
		int     idx;
		longint e;
		longint s;
		r = '0;
		e = c.e;
		s = c.s;
		case (c.func)
			FUNC_CLEAR: begin
				exp_cnt = 0;
				foreach (pt_cnt[i]) pt_cnt[i] = 0;
			end
			FUNC_WRITE: begin
				exp_tab[c.slot] = e;
				pt_cnt[c.slot] = 0;
				if (exp_cnt < c.slot + 1)
					exp_cnt = c.slot + 1;
			end
			FUNC_APPEND: begin
				if (c.slot >= exp_cnt || pt_cnt[c.slot] >= MAX_POINTS) begin
					r.status = STAT_REJECT;
				end else begin
					idx = c.slot * MAX_POINTS + pt_cnt[c.slot];
					stk_tab[idx] = s;
					vol_tab[idx] = c.pv;
					pt_cnt[c.slot]++;
				end
			end
			FUNC_QUERY: begin
				n = exp_cnt;
				if (n == 0) begin
					r.vol = dflt_vol[VOL_W-1:0];
					r.status = STAT_DEFAULT;
				end else begin
					if (n == 1 || e < exp_tab[0]) begin
						dn = 0;
						up = 0;
					end else if (e > exp_tab[n - 1]) begin
						dn = n - 1;
						up = n - 1;
					end else begin
						lo = 0;
						hi = n;
						while (lo < hi) begin
							mid = (lo + hi) / 2;
							if (exp_tab[mid] < e)
								lo = mid + 1;
							else
								hi = mid;
						end
						if (lo > n - 1)
							lo = n - 1;
						if (lo == 0)
							lo = 1;
						dn = lo - 1;
						up = lo;
					end
					if (pt_cnt[dn] == 0 || pt_cnt[up] == 0)
						r.status = STAT_REJECT;
					else if (dn == up)
						r.vol = smile_at(dn, s);
					else
						r.vol = blend(smile_at(dn, s), smile_at(up, s),
							e - exp_tab[dn], exp_tab[up] - exp_tab[dn]);
				end
			end
			FUNC_BFLY: r.arb = smile_nonconvex();
			default: ;
		endcase
		return r;
	endfunction

	// command generation; tracks the expiry count so no never-written slot is read
	task automatic push_cmd(logic [2:0] f, int sl, longint e, longint s, longint pv);
		cmd_t c;
		c.func = f;
		c.slot = sl[3:0];
		c.e = e[23:0];
		c.s = s[31:0];
		c.pv = pv[23:0];
		if (f == FUNC_CLEAR)
			gen_cnt = 0;
		else if (f == FUNC_WRITE && gen_cnt < sl + 1)
			gen_cnt = sl + 1;
		pending_cmds.push_back(c);
	endtask

	function automatic longint rand_s32();
		return longint'($signed($urandom()));
	endfunction

	task automatic surface_seq();
		int     ne;
		int     np;
		longint e;
		longint s;
		longint e_lo;
		longint s_lo;
		longint vbase;
		ne = $urandom_range(1, 5);
		e = $urandom_range(0, 20000);
		e_lo = e;
		s_lo = longint'($urandom_range(0, 1 << 26)) - (1 << 25);
		push_cmd(FUNC_CLEAR, 0, 0, 0, 0);
		for (int k = 0; k < ne; k++) begin
			push_cmd(FUNC_WRITE, k, e, 0, 0);
			np = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
			s = s_lo + $urandom_range(0, 1 << 20);
			vbase = $urandom_range(0, 3) == 0 ? $urandom_range(0, 24'hFFFFFF)
				: $urandom_range(400000, 1300000);
			for (int j = 0; j < np; j++) begin
				push_cmd(FUNC_APPEND, k, 0, s, $urandom_range(0, 3) == 0 ?
					$urandom_range(0, 24'hFFFFFF) : vbase + $urandom_range(0, 200000));
				s += $urandom_range(1, 1 << 22);
			end
			e += $urandom_range(1, 30000);
		end
		for (int q = 0; q < 8; q++) begin
			if ($urandom_range(0, 3) == 0)
				s = s_lo;
			else
				s = s_lo + longint'($urandom_range(0, 1 << 25)) - (1 << 22);
			push_cmd(FUNC_QUERY, 0, e_lo + $urandom_range(0, e - e_lo + 2000) - 1000,
				s, 0);
		end
		push_cmd(FUNC_BFLY, 0, 0, 0, 0);
	endtask

	task automatic noise_seq();
		logic [2:0] f;
		for (int k = 0; k < 10; k++) begin
			f = $urandom_range(0, 7);
			if (f == FUNC_CLEAR && $urandom_range(0, 3) != 0)
				f = FUNC_QUERY;
			if (f == FUNC_WRITE)
				push_cmd(f, $urandom_range(0, gen_cnt > 15 ? 15 : gen_cnt),
					$urandom_range(0, 24'hFFFFFF), rand_s32(), $urandom_range(0, 24'hFFFFFF));
			else
				push_cmd(f, $urandom_range(0, 15), $urandom_range(0, 24'hFFFFFF),
					rand_s32(), $urandom_range(0, 24'hFFFFFF));
		end
	endtask

	task automatic full_smile_seq();
		push_cmd(FUNC_CLEAR, 0, 0, 0, 0);
		push_cmd(FUNC_WRITE, 0, $urandom_range(0, 24'hFFFFFF), 0, 0);
		for (int j = 0; j <= MAX_POINTS; j++)
			push_cmd(FUNC_APPEND, 0, 0, longint'(j) * 100000 - 1600000,
				$urandom_range(0, 24'hFFFFFF));
		push_cmd(FUNC_QUERY, 0, 0, rand_s32() >>> 8, 0);
		push_cmd(FUNC_BFLY, 0, 0, 0, 0);
	endtask

	task automatic directed_seq();
		push_cmd(FUNC_CLEAR, 0, 0, 0, 0);
		push_cmd(FUNC_QUERY, 0, 24'hFFFFFF, 32'sh7FFFFFFF, 0);
		push_cmd(FUNC_APPEND, 0, 0, 0, 1000);
		push_cmd(FUNC_WRITE, 0, 0, 0, 0);
		push_cmd(FUNC_QUERY, 0, 0, 0, 0);
		push_cmd(FUNC_APPEND, 0, 0, -64'sd2147483648, 24'hFFFFFF);
		push_cmd(FUNC_APPEND, 0, 0, 0, 0);
		push_cmd(FUNC_APPEND, 0, 0, 64'sd2147483647, 24'hFFFFFF);
		push_cmd(FUNC_QUERY, 0, 0, -64'sd2147483648, 0);
		push_cmd(FUNC_QUERY, 0, 5, 12345678, 0);
		push_cmd(FUNC_QUERY, 0, 5, 64'sd2147483647, 0);
		push_cmd(FUNC_BFLY, 0, 0, 0, 0);
		push_cmd(FUNC_WRITE, 1, 24'hFFFFFF, 0, 0);
		push_cmd(FUNC_QUERY, 0, 1000, 0, 0);
		push_cmd(FUNC_APPEND, 1, 0, 0, 838861);
		push_cmd(FUNC_QUERY, 0, 24'h7FFFFF, -100, 0);
		push_cmd(FUNC_QUERY, 0, 24'hFFFFFF, 100, 0);
		push_cmd(FUNC_APPEND, 15, 0, 0, 1);
		push_cmd(5, 3, 24'hFFFFFF, -1, 24'hFFFFFF);
		push_cmd(6, 0, 0, 0, 0);
		push_cmd(7, 15, 1, 1, 1);
		push_cmd(FUNC_BFLY, 0, 0, 0, 0);
		push_cmd(FUNC_CLEAR, 0, 0, 0, 0);
		push_cmd(FUNC_QUERY, 0, 0, 0, 0);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_cmds.size() != 0 || item.valid || expected_res.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		if (idx == REG_DEFAULT_VOL)
			dflt_vol = val;
		else if (idx == REG_ARB_TOL)
			arb_tol = val[TOL_W-1:0];
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		int r;
		int target;
		errors = 0;
		gen_cnt = 0;
		exp_cnt = 0;
		foreach (pt_cnt[i]) pt_cnt[i] = 0;
		foreach (exp_tab[i]) exp_tab[i] = 0;
		foreach (stk_tab[i]) stk_tab[i] = 0;
		foreach (vol_tab[i]) vol_tab[i] = 0;
		dflt_vol = DEFAULT_VOL_RST;
		arb_tol = ARB_TOL_RST;
		cfg.valid <= 1'b0;
		cfg.index <= '0;
		cfg.data <= '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: begin
					write_reg(REG_DEFAULT_VOL, '0);
					write_reg(REG_ARB_TOL, '0);
				end
				2: begin
					write_reg(REG_DEFAULT_VOL, 24'hFFFFFF);
					write_reg(REG_ARB_TOL, 24'h00FFFF);
				end
				3: begin
					write_reg(REG_DEFAULT_VOL, $urandom_range(0, 24'hFFFFFF));
					write_reg(REG_ARB_TOL, $urandom_range(0, 16'hFFFF));
				end
				4: begin
					write_reg(REG_DEFAULT_VOL, 24'hAAAAAA);
					write_reg(REG_ARB_TOL, $urandom_range(0, 200));
				end
				default: ;
			endcase
			if (ph == 0)
				directed_seq();
			target = pending_cmds.size() + 215;
			full_smile_seq();
			while (pending_cmds.size() < target) begin
				r = $urandom_range(0, 9);
				if (r < 7)
					surface_seq();
				else
					noise_seq();
			end
			wait_idle();
		end
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// driver
	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item.valid <= 1'b0;
			item.func <= '0;
			item.slot <= '0;
			item.expiry_days <= '0;
			item.strike <= '0;
			item.point_vol <= '0;
			burst_left <= 1;
			gap_left <= 0;
		end else begin
			cmd_t c;
			if (item.valid && item.ready) begin
				c.func = item.func;
				c.slot = item.slot;
				c.e = item.expiry_days;
				c.s = item.strike;
				c.pv = item.point_vol;
				expected_res.push_back(surface_step(c));
			end
			if (!item.valid || item.ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					item.valid <= 1'b0;
				end else if (pending_cmds.size() != 0) begin
					c = pending_cmds.pop_front();
					item.valid <= 1'b1;
					item.func <= c.func;
					item.slot <= c.slot;
					item.expiry_days <= c.e;
					item.strike <= c.s;
					item.point_vol <= c.pv;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 30);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					item.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int  hold_left;
	bit  hold_done;
	int  mode_left;
	bit  stall_mode;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
			nres <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
			mode_left <= 0;
			stall_mode <= 1'b0;
		end else begin
			res_t got;
			res_t want;
			if (result.valid && result.ready) begin
				got.vol = result.vol;
				got.arb = result.butterfly_arb;
				got.status = result.status;
				nres <= nres + 1;
				if (expected_res.size() == 0) begin
					errors++;
					$display("%0t: unexpected result vol=%h arb=%b status=%0d",
						$time, got.vol, got.arb, got.status);
				end else begin
					want = expected_res.pop_front();
					if (got.vol !== want.vol) begin
						errors++;
						$display("%0t: vol expected %h actual %h", $time, want.vol, got.vol);
					end
					if (got.arb !== want.arb) begin
						errors++;
						$display("%0t: butterfly_arb expected %b actual %b",
							$time, want.arb, got.arb);
					end
					if (got.status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, got.status);
					end
				end
			end
			if (mode_left == 0) begin
				mode_left <= $urandom_range(20, 200);
				stall_mode <= $urandom_range(0, 1);
			end else begin
				mode_left <= mode_left - 1;
			end
			if (!hold_done && nres == 300) begin
				hold_done <= 1'b1;
				hold_left <= 500;
				result.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				result.ready <= 1'b0;
			end else if (stall_mode) begin
				result.ready <= ($urandom_range(0, 3) == 0);
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

endmodule
